@@ rtl/core/tmb_pkg.sv @@
// Package of the tile map blit command generator: constants, register indexes,
// the configuration struct and the queue entry type. No dependencies.
package tmb_pkg;

    localparam int CELL_PIXELS = 32;
    localparam int CELL_SHIFT  = $clog2(CELL_PIXELS);
    localparam int VIEW_WIDTH  = 480;
    localparam int VIEW_HEIGHT = 272;
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
    localparam int CELL_BITS   = 46;
    localparam int MAX_TPR     = 64;

    localparam logic [2:0] CFG_MAP_ROWS = 3'd0;
    localparam logic [2:0] CFG_MAP_COLS = 3'd1;
    localparam logic [2:0] CFG_SHEET0   = 3'd2;
    localparam logic [2:0] CFG_SHEET1   = 3'd3;
    localparam logic [2:0] CFG_SHEET2   = 3'd4;
    localparam logic [2:0] CFG_SHEET3   = 3'd5;

    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_SCROLL = 2'd1;
    localparam logic [1:0] ACT_DRAW   = 2'd2;

    typedef struct packed {
        logic [6:0]       map_rows;
        logic [6:0]       map_cols;
        logic [3:0][6:0]  tpr;
    } cfg_t;

    typedef struct packed {
        logic                  is_write;
        logic [ADDR_BITS-1:0]  addr;
        logic [CELL_BITS-1:0]  data;
        logic [4:0]            offx;
        logic [4:0]            offy;
        logic [5:0]            qw;
        logic [5:0]            qh;
        logic [8:0]            dx;
        logic [8:0]            dy;
        logic [2:0]            mask;
    } job_t;

endpackage

@@ rtl/core/tile_map_blit_command_generator.sv @@
// An accepted beat is classified by the front: valid writes and draws are
// queued, scrolls move the view. The back stores a queued write; for a draw
// it scans the layers, skips those whose mask bit is clear and divides each
// emitted tile number in the bit-serial tile divider; a draw holds the back
// until its layers are done, plus any output stall. Reset: asynchronous; the
// 4096-entry cell store is then cleared one entry a cycle, with in_stall high.
module tile_map_blit_command_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic signed [11:0] coord_a,
    input  logic signed [11:0] coord_b,
    input  logic [1:0]         ground_sheet,
    input  logic [7:0]         ground_tile,
    input  logic [1:0]         obj_sheet,
    input  logic [7:0]         obj_tile,
    input  logic [7:0]         obj_alpha,
    input  logic [1:0]         obj2_sheet,
    input  logic [7:0]         obj2_tile,
    input  logic [7:0]         obj2_alpha,
    input  logic [2:0]         layer_mask,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         layer_id,
    output logic [1:0]         sheet,
    output logic [10:0]        src_x,
    output logic [12:0]        src_y,
    output logic [5:0]         quad_width,
    output logic [5:0]         quad_height,
    output logic [8:0]         dest_x,
    output logic [8:0]         dest_y,
    output logic [7:0]         alpha,
    output logic               last
);
    import tmb_pkg::*;

    cfg_t  cfg_reg;
    logic  push, pop, q_full, q_empty, clearing;
    job_t  push_job, head_job;
    logic  [45:0] cell_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_rows <= 7'(MAX_ROWS);
            cfg_reg.map_cols <= 7'(MAX_COLS);
            cfg_reg.tpr      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAP_ROWS: cfg_reg.map_rows <= cfg_data;
                CFG_MAP_COLS: cfg_reg.map_cols <= cfg_data;
                CFG_SHEET0:   cfg_reg.tpr[0]   <= cfg_data;
                CFG_SHEET1:   cfg_reg.tpr[1]   <= cfg_data;
                CFG_SHEET2:   cfg_reg.tpr[2]   <= cfg_data;
                CFG_SHEET3:   cfg_reg.tpr[3]   <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign in_stall  = q_full || clearing;
    assign cell_data = {obj2_alpha, obj2_tile, obj2_sheet, obj_alpha, obj_tile,
                        obj_sheet, ground_tile, ground_sheet};

    tmb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (in_valid && !in_stall),
        .action     (action),
        .coord_a    (coord_a),
        .coord_b    (coord_b),
        .cell_data  (cell_data),
        .layer_mask (layer_mask),
        .push       (push),
        .push_job   (push_job)
    );

    tmb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    tmb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_job    (head_job),
        .q_empty     (q_empty),
        .pop         (pop),
        .clearing    (clearing),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .layer_id    (layer_id),
        .sheet       (sheet),
        .src_x       (src_x),
        .src_y       (src_y),
        .quad_width  (quad_width),
        .quad_height (quad_height),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .alpha       (alpha),
        .last        (last)
    );

endmodule

@@ rtl/core/tmb_queue.sv @@
// Two-entry queue of jobs between the front and the back of the generator.
// Depends on tmb_pkg for the job type.
module tmb_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tmb_pkg::job_t push_job,
    input  logic          pop,
    output tmb_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);
    import tmb_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign head_job = slot_reg[rd_ptr_reg];
    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);

endmodule

@@ rtl/core/tmb_front.sv @@
// Front of the generator: accepts beats, keeps the scroll position, checks
// writes and works out the clipped geometry of a draw. Depends on tmb_pkg.
module tmb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tmb_pkg::cfg_t     cfg,
    input  logic              accept,
    input  logic [1:0]        action,
    input  logic signed [11:0] coord_a,
    input  logic signed [11:0] coord_b,
    input  logic [45:0]       cell_data,
    input  logic [2:0]        layer_mask,
    output logic              push,
    output tmb_pkg::job_t     push_job
);
    import tmb_pkg::*;

    logic [11:0] view_left_reg, view_left_next;
    logic [11:0] view_top_reg, view_top_next;

    logic [6:0]  rows_eff, cols_eff;
    logic        wr_ok;
    logic signed [13:0] sum_l, sum_t, hi_l, hi_t, clamp_l, clamp_t;
    logic signed [17:0] left, top, right, bottom, lc, tc;
    logic [11:0] mrow, mcol;
    logic        draw_ok;

    always_comb
    begin
        rows_eff = (cfg.map_rows == 7'd0) ? 7'd1 :
                   (cfg.map_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg.map_rows;
        cols_eff = (cfg.map_cols == 7'd0) ? 7'd1 :
                   (cfg.map_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cfg.map_cols;

        wr_ok = !coord_a[11] && !coord_b[11] &&
                (coord_a[10:0] < {4'd0, rows_eff}) &&
                (coord_b[10:0] < {4'd0, cols_eff});

        sum_l = $signed({2'b00, view_left_reg}) + $signed({{2{coord_b[11]}}, coord_b});
        sum_t = $signed({2'b00, view_top_reg}) + $signed({{2{coord_a[11]}}, coord_a});
        hi_l  = $signed({2'b00, cols_eff, 5'd0}) - 14'(VIEW_WIDTH);
        hi_t  = $signed({2'b00, rows_eff, 5'd0}) - 14'(VIEW_HEIGHT);
        if (hi_l < 0)
        begin
            hi_l = '0;
        end
        if (hi_t < 0)
        begin
            hi_t = '0;
        end
        clamp_l = (sum_l > hi_l) ? hi_l : ((sum_l < 0) ? 14'sd0 : sum_l);
        clamp_t = (sum_t > hi_t) ? hi_t : ((sum_t < 0) ? 14'sd0 : sum_t);

        left   = $signed({2'b00, coord_b[10:0], 5'd0})
                 - $signed({13'd0, view_left_reg[CELL_SHIFT-1:0]});
        top    = $signed({2'b00, coord_a[10:0], 5'd0})
                 - $signed({13'd0, view_top_reg[CELL_SHIFT-1:0]});
        right  = left + 18'(CELL_PIXELS);
        bottom = top + 18'(CELL_PIXELS);
        if (right > 18'(VIEW_WIDTH))
        begin
            right = 18'(VIEW_WIDTH);
        end
        if (bottom > 18'(VIEW_HEIGHT))
        begin
            bottom = 18'(VIEW_HEIGHT);
        end
        lc = (left < 0) ? 18'sd0 : left;
        tc = (top < 0) ? 18'sd0 : top;

        mrow = {5'd0, view_top_reg[11:CELL_SHIFT]} + {1'b0, coord_a[10:0]};
        mcol = {5'd0, view_left_reg[11:CELL_SHIFT]} + {1'b0, coord_b[10:0]};

        draw_ok = !coord_a[11] && !coord_b[11] &&
                  (left < 18'(VIEW_WIDTH)) && (top < 18'(VIEW_HEIGHT)) &&
                  (mrow < {5'd0, rows_eff}) && (mcol < {5'd0, cols_eff});
    end

    always_comb
    begin
        push_job          = '0;
        push_job.is_write = (action == ACT_WRITE);
        push_job.data     = cell_data;
        push_job.mask     = layer_mask;
        push_job.offx     = (left < 0) ? 5'(-left) : 5'd0;
        push_job.offy     = (top < 0) ? 5'(-top) : 5'd0;
        push_job.qw       = 6'(right - lc);
        push_job.qh       = 6'(bottom - tc);
        push_job.dx       = 9'(lc);
        push_job.dy       = 9'(tc);
        if (action == ACT_WRITE)
        begin
            push_job.addr = {coord_a[ROW_BITS-1:0], coord_b[COL_BITS-1:0]};
        end
        else
        begin
            push_job.addr = {mrow[ROW_BITS-1:0], mcol[COL_BITS-1:0]};
        end
        push = accept && (((action == ACT_WRITE) && wr_ok) ||
                          ((action == ACT_DRAW) && draw_ok));

        view_left_next = view_left_reg;
        view_top_next  = view_top_reg;
        if (accept && (action == ACT_SCROLL))
        begin
            view_left_next = clamp_l[11:0];
            view_top_next  = clamp_t[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_left_reg <= '0;
            view_top_reg  <= '0;
        end
        else
        begin
            view_left_reg <= view_left_next;
            view_top_reg  <= view_top_next;
        end
    end

endmodule

@@ rtl/core/tmb_back.sv @@
// Back of the generator: holds the cell store, clears it after reset, runs
// queued writes and draws, divides tile numbers and emits quads. Uses tmb_pkg.
module tmb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  tmb_pkg::cfg_t cfg,
    input  tmb_pkg::job_t head_job,
    input  logic          q_empty,
    output logic          pop,
    output logic          clearing,
    input  logic          out_stall,
    output logic          out_valid,
    output logic [1:0]    layer_id,
    output logic [1:0]    sheet,
    output logic [10:0]   src_x,
    output logic [12:0]   src_y,
    output logic [5:0]    quad_width,
    output logic [5:0]    quad_height,
    output logic [8:0]    dest_x,
    output logic [8:0]    dest_y,
    output logic [7:0]    alpha,
    output logic          last
);
    import tmb_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CELL_BITS-1:0] mem [1 << ADDR_BITS];
    logic [CELL_BITS-1:0] cell_reg;
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    job_t                 job_reg;
    logic [1:0]           lay_reg, lay_next;
    logic [2:0]           step_reg, step_next;
    logic [6:0]           rem_reg, rem_next;
    logic [7:0]           quo_reg, quo_next;

    logic                 out_valid_reg, out_load;
    logic [1:0]           o_layer_reg, o_sheet_reg;
    logic [10:0]          o_sx_reg;
    logic [12:0]          o_sy_reg;
    logic [7:0]           o_alpha_reg;
    logic                 o_last_reg;

    logic [1:0]           cur_sh;
    logic [7:0]           cur_tile, cur_alpha;
    logic [2:0][1:0]      lay_sh;
    logic [2:0][6:0]      lay_tpr;
    logic [2:0]           vall, emit_vec, later;
    logic [6:0]           cur_tpr;
    logic [7:0]           trial;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [CELL_BITS-1:0] mem_wdata;

    always_comb
    begin
        lay_sh[0] = cell_reg[1:0];
        lay_sh[1] = cell_reg[11:10];
        lay_sh[2] = cell_reg[29:28];
        for (int k = 0; k < 3; k++)
        begin
            lay_tpr[k] = (cfg.tpr[lay_sh[k]] > 7'(MAX_TPR)) ? 7'(MAX_TPR)
                                                             : cfg.tpr[lay_sh[k]];
        end
        vall[0]  = (lay_tpr[0] != 7'd0);
        vall[1]  = vall[0] && (lay_tpr[1] != 7'd0);
        vall[2]  = vall[1] && (lay_tpr[2] != 7'd0);
        emit_vec = job_reg.mask & vall;

        unique case (lay_reg)
            2'd0:
            begin
                cur_sh = cell_reg[1:0];   cur_tile = cell_reg[9:2];
                cur_alpha = 8'hFF;        later = 3'b110;
            end
            2'd1:
            begin
                cur_sh = cell_reg[11:10]; cur_tile = cell_reg[19:12];
                cur_alpha = cell_reg[27:20]; later = 3'b100;
            end
            2'd2:
            begin
                cur_sh = cell_reg[29:28]; cur_tile = cell_reg[37:30];
                cur_alpha = cell_reg[45:38]; later = 3'b000;
            end
            default:
            begin
                cur_sh = '0; cur_tile = '0; cur_alpha = '0; later = 3'b000;
            end
        endcase
        cur_tpr = (cfg.tpr[cur_sh] > 7'(MAX_TPR)) ? 7'(MAX_TPR) : cfg.tpr[cur_sh];
        trial   = {rem_reg, quo_reg[7]};
    end

    always_comb
    begin
        state_next = state_reg;
        lay_next   = lay_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = head_job.addr;
        mem_wdata  = head_job.data;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    if (head_job.is_write)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        lay_next   = 2'd0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if ((lay_reg == 2'd3) || !vall[lay_reg])
                begin
                    state_next = ST_IDLE;
                end
                else if (!job_reg.mask[lay_reg])
                begin
                    lay_next = lay_reg + 2'd1;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = cur_tile;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, cur_tpr})
                begin
                    rem_next = 7'(trial - {1'b0, cur_tpr});
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[6:0];
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                step_next = step_reg + 3'd1;
                if (&step_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    lay_next   = lay_reg + 2'd1;
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            cell_reg <= mem[head_job.addr];
            job_reg  <= head_job;
        end
        if (out_load)
        begin
            o_layer_reg <= lay_reg;
            o_sheet_reg <= cur_sh;
            o_sx_reg    <= {rem_reg[5:0], 5'd0} + {6'd0, job_reg.offx};
            o_sy_reg    <= {quo_reg, 5'd0} + {8'd0, job_reg.offy};
            o_alpha_reg <= cur_alpha;
            o_last_reg  <= ~|(emit_vec & later);
            quad_width  <= job_reg.qw;
            quad_height <= job_reg.qh;
            dest_x      <= job_reg.dx;
            dest_y      <= job_reg.dy;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            lay_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lay_reg   <= lay_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_BITS'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign out_valid = out_valid_reg;
    assign layer_id  = o_layer_reg;
    assign sheet     = o_sheet_reg;
    assign src_x     = o_sx_reg;
    assign src_y     = o_sy_reg;
    assign alpha     = o_alpha_reg;
    assign last      = o_last_reg;

endmodule

@@ rtl/core/tmb_checker.sv @@
// Port-level checker of the tile map blit command generator, bound to the top.
// Depends only on the top level's ports.
module tmb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  layer_id,
    input logic [5:0]  quad_width,
    input logic [10:0] src_x
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(src_x) && $stable(layer_id))
        else $error("stalled output beat changed");

    a_layer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (layer_id != 2'd3) && (quad_width <= 6'd32))
        else $error("bad layer or quad width");

    a_clear: assert property (@(posedge clk)
        !rst_n |=> in_stall && !out_valid)
        else $error("input taken or output shown during clearing");

endmodule

bind tile_map_blit_command_generator tmb_checker u_tmb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .layer_id   (layer_id),
    .quad_width (quad_width),
    .src_x      (src_x)
);

@@ tb/tile_map_blit_command_generator_tb.sv @@
// Testbench of the tile map blit command generator: directed beats, then random phases under
// several register settings, each result beat checked against a built-in predictor.
// Depends on tmb_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tile_map_blit_command_generator_tb;
    import tmb_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS = 96;

    typedef struct {
        logic [1:0]         act;
        logic signed [11:0] a;
        logic signed [11:0] b;
        logic [1:0]         gs;
        logic [7:0]         gt;
        logic [1:0]         os;
        logic [7:0]         ot;
        logic [7:0]         oa;
        logic [1:0]         o2s;
        logic [7:0]         o2t;
        logic [7:0]         o2a;
        logic [2:0]         mask;
        int                 want;
    } beat_t;

    typedef struct packed {
        logic [1:0]  layer;
        logic [1:0]  sh;
        logic [10:0] sx;
        logic [12:0] sy;
        logic [5:0]  w;
        logic [5:0]  h;
        logic [8:0]  dx;
        logic [8:0]  dy;
        logic [7:0]  al;
        logic        lst;
    } quad_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [6:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = '0;
    logic signed [11:0] coord_a = '0;
    logic signed [11:0] coord_b = '0;
    logic [1:0] ground_sheet = '0;
    logic [7:0] ground_tile = '0;
    logic [1:0] obj_sheet = '0;
    logic [7:0] obj_tile = '0;
    logic [7:0] obj_alpha = '0;
    logic [1:0] obj2_sheet = '0;
    logic [7:0] obj2_tile = '0;
    logic [7:0] obj2_alpha = '0;
    logic [2:0] layer_mask = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] layer_id;
    logic [1:0] sheet;
    logic [10:0] src_x;
    logic [12:0] src_y;
    logic [5:0] quad_width;
    logic [5:0] quad_height;
    logic [8:0] dest_x;
    logic [8:0] dest_y;
    logic [7:0] alpha;
    logic last;

    tile_map_blit_command_generator i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [45:0] cells [MAX_ROWS*MAX_COLS];
    int view_left, view_top;
    int map_rows_reg, map_cols_reg;
    int tpr_reg [4];
    quad_t quads_due [$];
    int errors = 0;
    int idle_cycles = 0;
    bit no_gaps = 0;
    bit hold_req = 0;

    function automatic int eff_size(int v, int maxv);
        return v < 1 ? 1 : (v > maxv ? maxv : v);
    endfunction

    function automatic int clamp_view(int pos, int ncells, int vsize);
        int hi;
        hi = ncells * CELL_PIXELS - vsize;
        if (hi < 0) hi = 0;
        if (pos > hi) pos = hi;
        if (pos < 0) pos = 0;
        return pos;
    endfunction

    task automatic predict_quads(input beat_t t, output int n);
        int rows, cols, a, b, fx, fy, mrow, mcol, lft, tp, rgt, bot, offx, offy, tpr;
        logic [45:0] c;
        logic [1:0] sh;
        logic [7:0] tile, al;
        quad_t q;
        n = 0;
        rows = eff_size(map_rows_reg, MAX_ROWS);
        cols = eff_size(map_cols_reg, MAX_COLS);
        a = int'(t.a);
        b = int'(t.b);
        if (t.act == ACT_WRITE)
        begin
            if (a >= 0 && a < rows && b >= 0 && b < cols)
                cells[a*MAX_COLS+b] = {t.o2a, t.o2t, t.o2s, t.oa, t.ot, t.os, t.gt, t.gs};
        end
        else if (t.act == ACT_SCROLL)
        begin
            view_left = clamp_view(view_left + b, cols, VIEW_WIDTH);
            view_top = clamp_view(view_top + a, rows, VIEW_HEIGHT);
        end
        else if (t.act == ACT_DRAW && a >= 0 && b >= 0)
        begin
            fx = view_left % CELL_PIXELS;
            fy = view_top % CELL_PIXELS;
            mrow = view_top / CELL_PIXELS + a;
            mcol = view_left / CELL_PIXELS + b;
            lft = b * CELL_PIXELS - fx;
            tp = a * CELL_PIXELS - fy;
            if (lft < VIEW_WIDTH && tp < VIEW_HEIGHT && mrow < rows && mcol < cols)
            begin
                rgt = lft + CELL_PIXELS;
                bot = tp + CELL_PIXELS;
                offx = 0;
                offy = 0;
                if (lft < 0) begin offx = -lft; lft = 0; end
                if (tp < 0) begin offy = -tp; tp = 0; end
                if (rgt > VIEW_WIDTH) rgt = VIEW_WIDTH;
                if (bot > VIEW_HEIGHT) bot = VIEW_HEIGHT;
                c = cells[mrow*MAX_COLS+mcol];
                for (int ly = 0; ly < 3; ly++)
                begin
                    if (ly == 0) begin sh = c[1:0]; tile = c[9:2]; al = 8'd255; end
                    else if (ly == 1) begin sh = c[11:10]; tile = c[19:12]; al = c[27:20]; end
                    else begin sh = c[29:28]; tile = c[37:30]; al = c[45:38]; end
                    tpr = tpr_reg[sh] > MAX_TPR ? MAX_TPR : tpr_reg[sh];
                    if (tpr == 0) break;
                    if (t.mask[ly])
                    begin
                        q.layer = ly[1:0];
                        q.sh = sh;
                        q.sx = 11'((int'(tile) % tpr) * CELL_PIXELS + offx);
                        q.sy = 13'((int'(tile) / tpr) * CELL_PIXELS + offy);
                        q.w = 6'(rgt - lft);
                        q.h = 6'(bot - tp);
                        q.dx = 9'(lft);
                        q.dy = 9'(tp);
                        q.al = al;
                        q.lst = 1'b0;
                        quads_due.push_back(q);
                        n++;
                    end
                end
                if (n > 0) quads_due[$].lst = 1'b1;
            end
        end
    endtask

    task automatic send_beat(input beat_t t);
        int gap, n;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action <= t.act;
        coord_a <= t.a;
        coord_b <= t.b;
        ground_sheet <= t.gs;
        ground_tile <= t.gt;
        obj_sheet <= t.os;
        obj_tile <= t.ot;
        obj_alpha <= t.oa;
        obj2_sheet <= t.o2s;
        obj2_tile <= t.o2t;
        obj2_alpha <= t.o2a;
        layer_mask <= t.mask;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        predict_quads(t, n);
        if (t.want >= 0 && n != t.want)
        begin
            errors++;
            if (errors <= 10)
                $display("draw count mismatch: expected %0d quads, predicted %0d", t.want, n);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 7'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_MAP_ROWS) map_rows_reg = val & 127;
        else if (idx == CFG_MAP_COLS) map_cols_reg = val & 127;
        else tpr_reg[idx - CFG_SHEET0] = val & 127;
    endtask

    task automatic set_regs(input int r, input int c, input int t0, input int t1,
                            input int t2, input int t3);
        in_valid <= 1'b0;
        @(posedge clk);
        while (quads_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_MAP_ROWS, r);
        write_reg(CFG_MAP_COLS, c);
        write_reg(CFG_SHEET0, t0);
        write_reg(CFG_SHEET1, t1);
        write_reg(CFG_SHEET2, t2);
        write_reg(CFG_SHEET3, t3);
    endtask

    function automatic beat_t random_beat();
        beat_t t;
        int k, rows, cols;
        rows = eff_size(map_rows_reg, MAX_ROWS);
        cols = eff_size(map_cols_reg, MAX_COLS);
        k = $urandom_range(0, 99);
        t.gs = 2'($urandom); t.gt = 8'($urandom); t.os = 2'($urandom); t.ot = 8'($urandom);
        t.oa = 8'($urandom); t.o2s = 2'($urandom); t.o2t = 8'($urandom);
        t.o2a = 8'($urandom);
        t.mask = 3'($urandom); t.want = -1;
        t.a = 12'($urandom); t.b = 12'($urandom); t.act = 2'($urandom);
        if (k < 35)
        begin
            t.act = ACT_WRITE;
            t.a = 12'($urandom_range(0, rows - 1));
            t.b = 12'($urandom_range(0, cols - 1));
        end
        else if (k < 48)
        begin
            t.act = ACT_SCROLL;
            t.a = 12'($urandom_range(0, 200)) - 12'sd100;
            t.b = 12'($urandom_range(0, 200)) - 12'sd100;
        end
        else if (k < 92)
        begin
            t.act = ACT_DRAW;
            t.a = 12'($urandom_range(0, 10)) - 12'sd1;
            t.b = 12'($urandom_range(0, 16)) - 12'sd1;
        end
        return t;
    endfunction

    beat_t directed [] = '{
        '{ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 0},
        '{ACT_WRITE, 0, 0, 0, 255, 1, 255, 0, 2, 0, 255, 7, 0},
        '{ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 3},
        '{ACT_WRITE, 0, 1, 3, 8, 0, 1, 2, 0, 3, 4, 0, 0},
        '{ACT_DRAW, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 7, 0},
        '{ACT_WRITE, 1, 0, 1, 200, 3, 7, 9, 0, 5, 6, 0, 0},
        '{ACT_DRAW, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1},
        '{ACT_DRAW, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 6, 0},
        '{ACT_WRITE, -1, 0, 3, 3, 3, 3, 3, 3, 3, 3, 7, 0},
        '{ACT_WRITE, 64, 0, 3, 3, 3, 3, 3, 3, 3, 3, 7, 0},
        '{ACT_WRITE, 0, 64, 3, 3, 3, 3, 3, 3, 3, 3, 7, 0},
        '{ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_NONE, 5, 5, 3, 255, 3, 255, 255, 3, 255, 255, 7, 0},
        '{ACT_DRAW, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 0},
        '{ACT_DRAW, 0, -2048, 0, 0, 0, 0, 0, 0, 0, 0, 7, 0},
        '{ACT_SCROLL, 2047, 2047, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_WRITE, 63, 63, 2, 77, 1, 100, 128, 0, 63, 1, 0, 0},
        '{ACT_DRAW, 8, 14, 0, 0, 0, 0, 0, 0, 0, 0, 7, -1},
        '{ACT_DRAW, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7, 0},
        '{ACT_DRAW, 0, 15, 0, 0, 0, 0, 0, 0, 0, 0, 7, 0},
        '{ACT_SCROLL, -2048, -2048, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_SCROLL, 7, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ACT_DRAW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7, -1},
        '{ACT_DRAW, 8, 14, 0, 0, 0, 0, 0, 0, 0, 0, 7, -1},
        '{ACT_DRAW, 2047, 2047, 0, 0, 0, 0, 0, 0, 0, 0, 7, 0}
    };

    initial
    begin
        for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) cells[i] = '0;
        view_left = 0;
        view_top = 0;
        map_rows_reg = 64;
        map_cols_reg = 64;
        for (int i = 0; i < 4; i++) tpr_reg[i] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (in_stall) @(posedge clk);
        send_beat(directed[0]);
        set_regs(64, 64, 1, 64, 127, 0);
        for (int i = 1; i < directed.size(); i++) send_beat(directed[i]);
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_regs(64, 64, 1, 64, 127, 0);
                1: set_regs(0, 0, 5, 3, 1, 64);
                2: set_regs(127, 127, 64, 64, 64, 64);
                3: set_regs(3, 17, 2, 9, 0, 33);
                default: set_regs(64, 64, 7, 11, 13, 127);
            endcase
            no_gaps = (ph == 2);
            if (ph == 0) hold_req = 1;
            for (int i = 0; i < PHASE_ITEMS; i++) send_beat(random_beat());
        end
        in_valid <= 1'b0;
        while (quads_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int n;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (700) @(posedge clk);
                hold_req = 0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 8);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        quad_t got, exp_q;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got = {layer_id, sheet, src_x, src_y, quad_width, quad_height,
                   dest_x, dest_y, alpha, last};
            if (quads_due.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected quad beat %h", got);
            end
            else
            begin
                exp_q = quads_due.pop_front();
                if (got !== exp_q)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("quad mismatch: expected %p, got %p", exp_q, got);
                end
            end
        end
    end

endmodule

@@ tile_map_blit_command_generator.f @@
rtl/core/tmb_pkg.sv
rtl/core/tmb_queue.sv
rtl/core/tmb_front.sv
rtl/core/tmb_back.sv
rtl/core/tile_map_blit_command_generator.sv
rtl/core/tmb_checker.sv
tb/tile_map_blit_command_generator_tb.sv
